// ===== rtl/voxel_face_visibility_core_defines.svh =====
// Assertion helpers for the voxel face visibility core.
// Both sample on clk and are disabled while rst_n is low.
`ifndef VOXEL_FACE_VISIBILITY_CORE_DEFINES_SVH
`define VOXEL_FACE_VISIBILITY_CORE_DEFINES_SVH

// Same-cycle implication.
`define VFV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voxel_face_visibility_core: same-cycle check failed");

// Next-cycle implication.
`define VFV_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voxel_face_visibility_core: next-cycle check failed");

`endif

// ===== rtl/vfv_pkg.sv =====
`timescale 1ns / 1ps

package vfv_pkg;

    // Default chunk size
    localparam int SIZE_X_DEF = 16;
    localparam int SIZE_Y_DEF = 16;
    localparam int SIZE_Z_DEF = 16;

    // Coordinate width on the ports and widened width for range checks
    localparam int CRD_W = 6;
    localparam int EXT_W = 10;

    localparam int MASK_W = 6;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Read slots of a query: own voxel first, then the six neighbors
    localparam logic [2:0] SLOT_SELF = 3'd0;
    localparam logic [2:0] SLOT_XN   = 3'd1;
    localparam logic [2:0] SLOT_XP   = 3'd2;
    localparam logic [2:0] SLOT_YN   = 3'd3;
    localparam logic [2:0] SLOT_YP   = 3'd4;
    localparam logic [2:0] SLOT_ZN   = 3'd5;
    localparam logic [2:0] SLOT_ZP   = 3'd6;

    typedef struct packed {
        logic invisible;
        logic translucent;
        logic present;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // A face is exposed when the neighbor is absent, invisible, or
    // translucent while this voxel is opaque.
    function automatic logic face_exposed(entry_t nb, logic self_tr);
        return !nb.present || nb.invisible || (nb.translucent && !self_tr);
    endfunction

endpackage

// ===== rtl/vfv_in_if.sv =====
`timescale 1ns / 1ps

interface vfv_in_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic signed [vfv_pkg::CRD_W-1:0]  x_pos;
    logic signed [vfv_pkg::CRD_W-1:0]  y_pos;
    logic signed [vfv_pkg::CRD_W-1:0]  z_pos;
    logic                              present;
    logic                              translucent;
    logic                              invisible;

    modport source (
        output valid, cmd, x_pos, y_pos, z_pos, present, translucent, invisible,
        input  ready
    );

    modport sink (
        input  valid, cmd, x_pos, y_pos, z_pos, present, translucent, invisible,
        output ready
    );
endinterface

// ===== rtl/vfv_out_if.sv =====
`timescale 1ns / 1ps

interface vfv_out_if;
    logic                              valid;
    logic                              ready;
    logic [vfv_pkg::MASK_W-1:0]        face_mask;
    logic                              coord_error;

    modport source (
        output valid, face_mask, coord_error,
        input  ready
    );

    modport sink (
        input  valid, face_mask, coord_error,
        output ready
    );
endinterface

// ===== rtl/vfv_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read.
module vfv_ram #(
    parameter int WIDTH = vfv_pkg::ENTRY_W,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/voxel_face_visibility_core.sv =====
`timescale 1ns / 1ps

// Voxel face visibility core. Holds the voxels of one SIZE_X x SIZE_Y x
// SIZE_Z chunk plus a one-voxel halo from the neighboring chunks in a
// single RAM of (SIZE_X+2)*(SIZE_Y+2)*(SIZE_Z+2) three-bit entries
// (present, translucent, invisible). A write transaction (cmd = 0) loads
// one entry, halo included; coordinates outside -1..SIZE on any axis are
// dropped without a result. A query transaction (cmd = 1) returns one
// result: the six-bit exposed-face mask of an interior voxel, or
// coord_error = 1 with a zero mask for anything outside the interior.
// After reset the core runs a clearing pass of one entry per cycle over
// the whole store and accepts nothing until it is done. The core handles
// one transaction at a time. A write is accepted and then written to the
// RAM. An interior query is accepted, then issues seven RAM reads (the voxel
// and its six neighbors through the single read port), waits for the last
// read data, and loads the result register. An out-of-interior query goes
// straight from accept to the result load. The result register lets the
// next transaction be accepted while a result still waits; a query stalls
// at its end until that register is free.
`include "voxel_face_visibility_core_defines.svh"

module voxel_face_visibility_core #(
    parameter int SIZE_X = vfv_pkg::SIZE_X_DEF,
    parameter int SIZE_Y = vfv_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z = vfv_pkg::SIZE_Z_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    vfv_in_if.sink    item,
    vfv_out_if.source result
);

    // Store geometry
    localparam int DEPTH = (SIZE_X + 2) * (SIZE_Y + 2) * (SIZE_Z + 2);
    localparam int AW    = $clog2(DEPTH);

    localparam logic [AW-1:0] STRIDE_Y = AW'(SIZE_X + 2);
    localparam logic [AW-1:0] STRIDE_Z = AW'((SIZE_X + 2) * (SIZE_Y + 2));
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    localparam int EXT_W = vfv_pkg::EXT_W;

    // Coordinate limits, signed for the range checks
    localparam logic signed [EXT_W-1:0] HALO_LO = '1;
    localparam logic signed [EXT_W-1:0] ZERO    = '0;
    localparam logic signed [EXT_W-1:0] LIM_X   = EXT_W'(SIZE_X);
    localparam logic signed [EXT_W-1:0] LIM_Y   = EXT_W'(SIZE_Y);
    localparam logic signed [EXT_W-1:0] LIM_Z   = EXT_W'(SIZE_Z);

    vfv_pkg::state_t state_reg, state_next;

    logic [AW-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [2:0]                 rd_cnt_reg, rd_cnt_next;
    logic                       rd_valid_reg, rd_valid_next;
    logic [2:0]                 rd_slot_reg, rd_slot_next;
    logic [AW-1:0]              base_reg, base_next;
    vfv_pkg::entry_t            entry_reg, entry_next;
    logic                       in_store_reg, in_store_next;
    logic                       err_reg, err_next;
    logic                       self_tr_reg, self_tr_next;
    logic [vfv_pkg::MASK_W-1:0] mask_reg, mask_next;
    logic                       out_valid_reg, out_valid_next;
    logic [vfv_pkg::MASK_W-1:0] out_mask_reg, out_mask_next;
    logic                       out_err_reg, out_err_next;

    // Input decode
    logic signed [EXT_W-1:0] x_ext, y_ext, z_ext;
    logic                    in_store, interior;
    logic [AW-1:0]           xi, yi, zi, in_index;
    logic                    in_ready, in_fire, out_free, out_load;

    // RAM ports
    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    vfv_pkg::entry_t         ram_wdata, ram_rdata;

    assign x_ext = EXT_W'(item.x_pos);
    assign y_ext = EXT_W'(item.y_pos);
    assign z_ext = EXT_W'(item.z_pos);

    assign in_store = (x_ext >= HALO_LO) && (x_ext <= LIM_X)
                   && (y_ext >= HALO_LO) && (y_ext <= LIM_Y)
                   && (z_ext >= HALO_LO) && (z_ext <= LIM_Z);
    assign interior = (x_ext >= ZERO) && (x_ext < LIM_X)
                   && (y_ext >= ZERO) && (y_ext < LIM_Y)
                   && (z_ext >= ZERO) && (z_ext < LIM_Z);

    // Shift by one so the low halo lands on index zero
    assign xi = AW'(x_ext + EXT_W'(1));
    assign yi = AW'(y_ext + EXT_W'(1));
    assign zi = AW'(z_ext + EXT_W'(1));
    assign in_index = xi + yi * STRIDE_Y + zi * STRIDE_Z;

    assign out_free = !out_valid_reg || result.ready;
    assign in_fire  = item.valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vfv_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = vfv_pkg::ST_IDLE;
                end
            end
            vfv_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (item.cmd == vfv_pkg::CMD_WRITE)
                    begin
                        state_next = vfv_pkg::ST_WRITE;
                    end
                    else if (interior)
                    begin
                        state_next = vfv_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = vfv_pkg::ST_OUT;
                    end
                end
            end
            vfv_pkg::ST_WRITE:
            begin
                state_next = vfv_pkg::ST_IDLE;
            end
            vfv_pkg::ST_READ:
            begin
                if (rd_cnt_reg == vfv_pkg::SLOT_ZP)
                begin
                    state_next = vfv_pkg::ST_DRAIN;
                end
            end
            vfv_pkg::ST_DRAIN:
            begin
                state_next = vfv_pkg::ST_OUT;
            end
            vfv_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = vfv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vfv_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake, RAM control, result load
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = base_reg;
        out_load  = 1'b0;
        unique case (state_reg)
            vfv_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            vfv_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            vfv_pkg::ST_WRITE:
            begin
                ram_we    = in_store_reg;
                ram_waddr = base_reg;
                ram_wdata = entry_reg;
            end
            vfv_pkg::ST_READ:
            begin
                ram_re = 1'b1;
                unique case (rd_cnt_reg)
                    vfv_pkg::SLOT_SELF: ram_raddr = base_reg;
                    vfv_pkg::SLOT_XN:   ram_raddr = base_reg - AW'(1);
                    vfv_pkg::SLOT_XP:   ram_raddr = base_reg + AW'(1);
                    vfv_pkg::SLOT_YN:   ram_raddr = base_reg - STRIDE_Y;
                    vfv_pkg::SLOT_YP:   ram_raddr = base_reg + STRIDE_Y;
                    vfv_pkg::SLOT_ZN:   ram_raddr = base_reg - STRIDE_Z;
                    vfv_pkg::SLOT_ZP:   ram_raddr = base_reg + STRIDE_Z;
                    default:            ram_raddr = base_reg;
                endcase
            end
            vfv_pkg::ST_DRAIN:
            begin
                ram_re = 1'b0;
            end
            vfv_pkg::ST_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_valid_next  = ram_re;
        rd_slot_next   = rd_cnt_reg;
        base_next      = base_reg;
        entry_next     = entry_reg;
        in_store_next  = in_store_reg;
        err_next       = err_reg;
        self_tr_next   = self_tr_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        out_mask_next  = out_mask_reg;
        out_err_next   = out_err_reg;

        if (state_reg == vfv_pkg::ST_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        // Capture the transaction
        if (in_fire)
        begin
            base_next              = in_index;
            in_store_next          = in_store;
            entry_next.present     = item.present;
            entry_next.translucent = item.translucent;
            entry_next.invisible   = item.invisible;
            err_next               = !interior;
            mask_next              = '0;
            rd_cnt_next            = vfv_pkg::SLOT_SELF;
        end

        // Advance the read sequence
        if (ram_re)
        begin
            rd_cnt_next = rd_cnt_reg + 3'd1;
        end

        // Fold in returning read data: own voxel first, then neighbors
        if (rd_valid_reg)
        begin
            if (rd_slot_reg == vfv_pkg::SLOT_SELF)
            begin
                self_tr_next = ram_rdata.translucent;
            end
            else
            begin
                mask_next[3'(rd_slot_reg - 3'd1)] =
                    vfv_pkg::face_exposed(ram_rdata, self_tr_reg);
            end
        end

        // Result register
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_mask_next  = mask_reg;
            out_err_next   = err_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vfv_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            rd_cnt_reg    <= vfv_pkg::SLOT_SELF;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_slot_reg  <= rd_slot_next;
        base_reg     <= base_next;
        entry_reg    <= entry_next;
        in_store_reg <= in_store_next;
        err_reg      <= err_next;
        self_tr_reg  <= self_tr_next;
        mask_reg     <= mask_next;
        out_mask_reg <= out_mask_next;
        out_err_reg  <= out_err_next;
    end

    vfv_ram #(
        .WIDTH (vfv_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign item.ready         = in_ready;
    assign result.valid       = out_valid_reg;
    assign result.face_mask   = out_mask_reg;
    assign result.coord_error = out_err_reg;

    // A result appears only out of the result-load state
    `VFV_ASSERT_IMP(a_result_from_out, $rose(out_valid_reg), $past(state_reg) == vfv_pkg::ST_OUT)
    // Read data returns only for reads issued in the read sequence
    `VFV_ASSERT_IMP(a_read_origin, rd_valid_reg, $past(state_reg) == vfv_pkg::ST_READ)
    // A coordinate error carries a zero mask
    `VFV_ASSERT_IMP(a_err_mask_zero, out_valid_reg && out_err_reg, out_mask_reg == '0)
    // No result can be pending while the store is still being cleared
    `VFV_ASSERT_NXT(a_clear_quiet, state_reg == vfv_pkg::ST_CLEAR, !out_valid_reg)

endmodule

// ===== verif/face_mask_checker.sv =====
`timescale 1ns / 1ps

module face_mask_checker
    import vfv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vfv_in_if    item_mon,
    vfv_out_if   result_mon,
    output int   fail_count,
    output int   pending
);

    localparam int DIM_X       = SIZE_X_DEF + 2;
    localparam int DIM_Y       = SIZE_Y_DEF + 2;
    localparam int DIM_Z       = SIZE_Z_DEF + 2;
    localparam int STORE_DEPTH = DIM_X * DIM_Y * DIM_Z;
    localparam int MAX_LINES   = 40;

    typedef struct packed {
        logic [MASK_W-1:0] face_mask;
        logic              coord_error;
    } face_result_t;

    entry_t       voxel_model [STORE_DEPTH];
    face_result_t expected_faces_q [$];
    int           mismatch_total = 0;

    assign fail_count = mismatch_total;

    initial
    begin
        foreach (voxel_model[i])
        begin
            voxel_model[i] = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_total < MAX_LINES)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_total++;
    endtask

    function automatic int vox_index(input int xi, input int yi, input int zi);
        return (xi + 1) + (yi + 1) * DIM_X + (zi + 1) * DIM_X * DIM_Y;
    endfunction

    function automatic bit within_store(input int xi, input int yi, input int zi);
        return xi >= -1 && xi <= SIZE_X_DEF && yi >= -1 && yi <= SIZE_Y_DEF &&
               zi >= -1 && zi <= SIZE_Z_DEF;
    endfunction

    function automatic bit within_chunk(input int xi, input int yi, input int zi);
        return xi >= 0 && xi < SIZE_X_DEF && yi >= 0 && yi < SIZE_Y_DEF &&
               zi >= 0 && zi < SIZE_Z_DEF;
    endfunction

    // Faces in mask order: -x, +x, -y, +y, -z, +z.
    function automatic face_result_t predict_faces(input int xi, input int yi, input int zi);
        face_result_t res;
        entry_t       nb;
        logic         self_tr;
        int           nx;
        int           ny;
        int           nz;
        res = '0;
        if (!within_chunk(xi, yi, zi))
        begin
            res.coord_error = 1'b1;
            return res;
        end
        self_tr = voxel_model[vox_index(xi, yi, zi)].translucent;
        for (int f = 0; f < MASK_W; f++)
        begin
            nx = xi + ((f == 0) ? -1 : (f == 1) ? 1 : 0);
            ny = yi + ((f == 2) ? -1 : (f == 3) ? 1 : 0);
            nz = zi + ((f == 4) ? -1 : (f == 5) ? 1 : 0);
            nb = voxel_model[vox_index(nx, ny, nz)];
            res.face_mask[f] = !nb.present || nb.invisible || (nb.translucent && !self_tr);
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        face_result_t want;
        entry_t       wr;
        int           xi;
        int           yi;
        int           zi;
        if (rst_n)
        begin
            // Check the result side first: a query accepted at this edge
            // cannot have its result at the same edge.
            if (result_mon.valid && result_mon.ready)
            begin
                if (expected_faces_q.size() == 0)
                begin
                    report_mismatch($sformatf("result mask %0d err %0d with no query pending",
                                              result_mon.face_mask, result_mon.coord_error));
                end
                else
                begin
                    want = expected_faces_q.pop_front();
                    if (result_mon.face_mask !== want.face_mask)
                    begin
                        report_mismatch($sformatf("face_mask got %b expected %b",
                                                  result_mon.face_mask, want.face_mask));
                    end
                    if (result_mon.coord_error !== want.coord_error)
                    begin
                        report_mismatch($sformatf("coord_error got %b expected %b",
                                                  result_mon.coord_error,
                                                  want.coord_error));
                    end
                end
            end
            if (item_mon.valid && item_mon.ready)
            begin
                xi = int'(item_mon.x_pos);
                yi = int'(item_mon.y_pos);
                zi = int'(item_mon.z_pos);
                if (item_mon.cmd == CMD_WRITE)
                begin
                    if (within_store(xi, yi, zi))
                    begin
                        wr.present     = item_mon.present;
                        wr.translucent = item_mon.translucent;
                        wr.invisible   = item_mon.invisible;
                        voxel_model[vox_index(xi, yi, zi)] = wr;
                    end
                end
                else
                begin
                    expected_faces_q.push_back(predict_faces(xi, yi, zi));
                end
            end
            pending <= expected_faces_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import vfv_pkg::*;

    // Generous cycle budget: it covers the clearing pass after reset, and
    // each item's core time, sender gap and receiver stall.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 750;
    localparam int FOCUS_SPAN   = 30;
    localparam int TAIL_CYCLES  = 30;

    logic clk = 1'b0;
    logic rst_n;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Sender burst bookkeeping: transactions left in the current burst.
    int burst_left = 0;

    // Receiver stall pattern: level to hold and cycles left to hold it.
    logic ready_level = 1'b1;
    int   ready_left  = 0;

    vfv_in_if  in_ch ();
    vfv_out_if out_ch ();

    voxel_face_visibility_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch)
    );

    face_mask_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_mon   (in_ch),
        .result_mon (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: end the run if it hangs anywhere, including the clearing pass.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: alternate between long free-flowing stretches, short
    // random flicker and solid stalls, each held for a random length.
    always @(posedge clk)
    begin
        int mode;
        if (ready_left == 0)
        begin
            mode = $urandom_range(9);
            if (mode < 3)
            begin
                ready_level = 1'b1;
                ready_left  = $urandom_range(20, 80);
            end
            else if (mode < 7)
            begin
                ready_level = 1'($urandom_range(1));
                ready_left  = $urandom_range(1, 4);
            end
            else
            begin
                ready_level = 1'b0;
                ready_left  = $urandom_range(1, 15);
            end
        end
        else
        begin
            ready_left--;
        end
        out_ch.ready <= ready_level;
    end

    // Drive one transaction and hold it until the core takes it. When a
    // burst runs out, drop valid for a random gap and start a new burst;
    // inside a burst valid stays high from one transaction to the next.
    task automatic send_item(input logic cmd_v, input int xv, input int yv, input int zv,
                             input logic pr, input logic tr, input logic iv);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            // Mostly short bursts, now and then a long stretch with no gaps.
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 90)
                                                  : $urandom_range(1, 10);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd_v;
        in_ch.x_pos       <= CRD_W'(xv);
        in_ch.y_pos       <= CRD_W'(yv);
        in_ch.z_pos       <= CRD_W'(zv);
        in_ch.present     <= pr;
        in_ch.translucent <= tr;
        in_ch.invisible   <= iv;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        burst_left--;
    endtask

    // Hold the sender off until every pending result has been taken.
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Pick a focus coordinate, biased toward the chunk faces so the halo
    // gets exercised often.
    function automatic int pick_focus(input int size);
        int roll;
        roll = $urandom_range(9);
        if (roll < 2)
        begin
            return 0;
        end
        else if (roll < 4)
        begin
            return size - 1;
        end
        return $urandom_range(size - 1);
    endfunction

    initial
    begin
        int   fx;
        int   fy;
        int   fz;
        int   roll;
        logic pr;
        logic tr;
        logic iv;

        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= CMD_WRITE;
        in_ch.x_pos       <= '0;
        in_ch.y_pos       <= '0;
        in_ch.z_pos       <= '0;
        in_ch.present     <= 1'b0;
        in_ch.translucent <= 1'b0;
        in_ch.invisible   <= 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The core stays not-ready through its clearing
        // pass, so the first transaction simply waits for it.

        // Nothing written yet: every neighbor, halo included, is absent.
        send_item(CMD_QUERY, 0, 0, 0, 1'b0, 1'b0, 1'b0);

        // Out-of-interior queries: halo on each side and the extreme codes.
        send_item(CMD_QUERY, -1, 0, 0, 1'b1, 1'b1, 1'b1);
        send_item(CMD_QUERY, 16, 15, 15, 1'b0, 1'b0, 1'b0);
        send_item(CMD_QUERY, 3, 3, -32, 1'b0, 1'b0, 1'b0);
        send_item(CMD_QUERY, 31, 31, 31, 1'b0, 1'b0, 1'b0);

        // Opaque voxel surrounded by one neighbor of each kind:
        // opaque, translucent, invisible, absent, and all bits set.
        send_item(CMD_WRITE, 5, 5, 5, 1'b1, 1'b0, 1'b0);
        send_item(CMD_WRITE, 4, 5, 5, 1'b1, 1'b0, 1'b0);
        send_item(CMD_WRITE, 6, 5, 5, 1'b1, 1'b1, 1'b0);
        send_item(CMD_WRITE, 5, 4, 5, 1'b1, 1'b0, 1'b1);
        send_item(CMD_WRITE, 5, 6, 5, 1'b0, 1'b1, 1'b0);
        send_item(CMD_WRITE, 5, 5, 4, 1'b1, 1'b1, 1'b1);
        send_item(CMD_WRITE, 5, 5, 6, 1'b1, 1'b0, 1'b0);
        send_item(CMD_QUERY, 5, 5, 5, 1'b0, 1'b0, 1'b0);

        // Turn the center translucent: the translucent neighbor now hides.
        send_item(CMD_WRITE, 5, 5, 5, 1'b1, 1'b1, 1'b0);
        send_item(CMD_QUERY, 5, 5, 5, 1'b1, 1'b1, 1'b1);

        // Halo writes on the low corner and the high corner.
        send_item(CMD_WRITE, -1, 0, 0, 1'b1, 1'b0, 1'b0);
        send_item(CMD_WRITE, 0, -1, 0, 1'b1, 1'b0, 1'b0);
        send_item(CMD_QUERY, 0, 0, 0, 1'b0, 1'b0, 1'b0);
        send_item(CMD_WRITE, 16, 15, 15, 1'b1, 1'b0, 1'b0);
        send_item(CMD_QUERY, 15, 15, 15, 1'b0, 1'b0, 1'b0);

        // Writes outside the store must be dropped; query the voxels that a
        // wrapped address would land next to.
        send_item(CMD_WRITE, 17, 5, 5, 1'b1, 1'b0, 1'b0);
        send_item(CMD_WRITE, 5, -2, 5, 1'b1, 1'b0, 1'b0);
        send_item(CMD_WRITE, 5, 5, -32, 1'b1, 1'b0, 1'b0);
        send_item(CMD_QUERY, 0, 6, 5, 1'b0, 1'b0, 1'b0);
        send_item(CMD_QUERY, 5, 15, 4, 1'b0, 1'b0, 1'b0);

        // Random part: build up a small neighborhood around a focus voxel,
        // query inside it, and move the focus now and then. A slice of
        // the traffic is raw noise over the full 6-bit coordinate range.
        fx = 0;
        fy = 0;
        fz = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % FOCUS_SPAN == 0)
            begin
                fx = pick_focus(SIZE_X_DEF);
                fy = pick_focus(SIZE_Y_DEF);
                fz = pick_focus(SIZE_Z_DEF);
            end
            if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3)
            begin
                hold_until_drained();
            end
            roll = $urandom_range(99);
            pr   = ($urandom_range(3) != 0);
            tr   = 1'($urandom_range(1));
            iv   = ($urandom_range(3) == 0);
            if (roll < 55)
            begin
                send_item(CMD_WRITE, fx + $urandom_range(2) - 1, fy + $urandom_range(2) - 1,
                          fz + $urandom_range(2) - 1, pr, tr, iv);
            end
            else if (roll < 88)
            begin
                send_item(CMD_QUERY, fx + $urandom_range(2) - 1, fy + $urandom_range(2) - 1,
                          fz + $urandom_range(2) - 1, pr, tr, iv);
            end
            else
            begin
                send_item(1'($urandom_range(1)), $urandom_range(63), $urandom_range(63),
                          $urandom_range(63), pr, tr, iv);
            end
        end

        // Drain: wait for every pending result, then linger a little to
        // catch anything spurious coming out of the core.
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== voxel_face_visibility_core.f =====
+incdir+rtl
rtl/vfv_pkg.sv
rtl/vfv_in_if.sv
rtl/vfv_out_if.sv
rtl/vfv_ram.sv
rtl/voxel_face_visibility_core.sv
verif/face_mask_checker.sv
verif/testbench.sv
